// File: rtl/tsw_pkg.sv
// Shared types and constants of the texture sampler with wrap and filter.
// No dependencies; used by every other file in rtl.
package tsw_pkg;

    localparam int FMAX  = 24;  // widest coordinate fraction supported
    localparam int IDX_W = 12;  // texel index bits (sizes up to 4096)
    localparam int DIM_W = 13;  // effective texture size, 1..4096

    localparam logic [1:0] WRAP_CLAMP  = 2'd0;
    localparam logic [1:0] WRAP_REPEAT = 2'd1;
    localparam logic [1:0] WRAP_MIRROR = 2'd2;

    localparam logic [1:0] FILT_NEAREST = 2'd0;
    localparam logic [1:0] FILT_SMOOTH  = 2'd2;

    localparam logic [2:0] REG_WRAP   = 3'd0;
    localparam logic [2:0] REG_FILTER = 3'd1;
    localparam logic [2:0] REG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SOURCE = 3'd4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [1:0] wrap_mode;
        logic [1:0] filter_mode;
        logic [8:0] tex_width;
        logic [8:0] tex_height;
        logic       source_present;
    } t_cfg;

    // one classified item between front and back
    typedef struct packed {
        logic              op;
        logic              white;
        logic [IDX_W-1:0]  x0;
        logic [IDX_W-1:0]  x1;
        logic [IDX_W-1:0]  y0;
        logic [IDX_W-1:0]  y1;
        logic [FMAX-1:0]   fx;
        logic [FMAX-1:0]   fy;
        logic [31:0]       color;
    } t_job;

endpackage

// File: rtl/tsw_front.sv
// Front end: takes input beats, wraps and scales coordinates, emits jobs.
// Depends on tsw_pkg.
module tsw_front #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsw_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [19:0]   i_u,
    input  logic [19:0]   i_v,
    input  logic [31:0]   i_color,
    output logic          o_push,
    output tsw_pkg::t_job o_job,
    input  logic          i_q_ready
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int CW = tsw_pkg::FMAX + 1;
    localparam int DW = tsw_pkg::DIM_W;
    localparam int SW = CW + DW;

    logic              r_v, r_op, r_white;
    logic [CW-1:0]     r_wu, r_wv;
    logic [31:0]       r_col;
    logic [DW-1:0]     weff, heff;
    logic [SW-1:0]     su, sv;
    logic [DW:0]       iu, iv;
    logic              take;

    function automatic logic [CW-1:0] wrap(input logic [19:0] raw, input logic [1:0] mode);
        logic signed [27:0] c;
        logic signed [27:0] one;
        c   = 28'(signed'(raw));
        one = 28'sd1 <<< F;
        if (mode == tsw_pkg::WRAP_MIRROR) begin
            if (c < 0) c = -c;
            else if (c >= one) c = 28'sd2 * one - c;
        end else if (mode == tsw_pkg::WRAP_REPEAT) begin
            c = c & (one - 28'sd1);
        end
        if (c < 0) c = '0;
        if (c > one) c = one;
        return CW'(c);
    endfunction

    function automatic logic [DW-1:0] eff(input logic [8:0] d, input int maxd);
        if (d == 9'd0) return DW'(1);
        if (DW'(d) > DW'(maxd)) return DW'(maxd);
        return DW'(d);
    endfunction

    function automatic logic [tsw_pkg::IDX_W-1:0] clip(input logic [DW:0] i,
                                                       input logic [DW-1:0] s);
        if (i >= (DW+1)'(s)) return tsw_pkg::IDX_W'(s - DW'(1));
        return tsw_pkg::IDX_W'(i);
    endfunction

    assign weff = eff(i_cfg.tex_width, MAX_WIDTH);
    assign heff = eff(i_cfg.tex_height, MAX_HEIGHT);

    assign o_push  = r_v && i_q_ready;
    assign o_ready = !r_v || i_q_ready;
    assign take    = i_valid && o_ready;

    // stage 1: wrap; a write with no texture attached is dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= take && (i_cfg.source_present || i_op == tsw_pkg::OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op    <= i_op;
            r_white <= !i_cfg.source_present;
            r_wu    <= wrap(i_u, i_cfg.wrap_mode);
            r_wv    <= wrap(i_v, i_cfg.wrap_mode);
            r_col   <= i_color;
        end
    end

    // stage 2: scale by size, split index and fraction, clamp to edge
    assign su = SW'(r_wu) * SW'(weff);
    assign sv = SW'(r_wv) * SW'(heff);
    assign iu = (DW+1)'(su >> F);
    assign iv = (DW+1)'(sv >> F);

    always_comb begin
        o_job.op    = r_op;
        o_job.white = r_white;
        o_job.x0    = clip(iu, weff);
        o_job.x1    = clip(iu + (DW+1)'(1), weff);
        o_job.y0    = clip(iv, heff);
        o_job.y1    = clip(iv + (DW+1)'(1), heff);
        o_job.fx    = tsw_pkg::FMAX'(su & ((SW'(1) << F) - SW'(1)));
        o_job.fy    = tsw_pkg::FMAX'(sv & ((SW'(1) << F) - SW'(1)));
        o_job.color = r_col;
    end
endmodule

// File: rtl/tsw_queue.sv
// Four-entry job queue between front and back.
// Depends on tsw_pkg.
module tsw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsw_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output tsw_pkg::t_job o_job,
    input  logic          i_pop
);
    tsw_pkg::t_job r_q [4];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_job;
    end
endmodule

// File: rtl/tsw_back.sv
// Back end: texel memory, smoothstep unit, four-tap fetch and blend.
// Depends on tsw_pkg.
module tsw_back #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_filter,
    input  logic          i_q_valid,
    input  tsw_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_data
);
    localparam int F  = COORD_FRAC_BITS;
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WW = tsw_pkg::FMAX + 1;
    localparam int TW = 8 + WW + 1;
    localparam int SW = TW + WW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SM1  = 3'd1;
    localparam logic [2:0] ST_SM2  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_HOR  = 3'd4;
    localparam logic [2:0] ST_VER  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [31:0]   r_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [31:0]   r_mem_q;
    logic [2:0]    r_st;
    logic          r_sel;
    logic [2:0]    r_rc;
    tsw_pkg::t_job r_job;
    logic [WW-1:0] r_fx, r_fy, r_f2;
    logic [31:0]   r_tex [4];
    logic [TW-1:0] r_top [4];
    logic [TW-1:0] r_bot [4];
    logic [31:0]   r_res;
    logic          r_ov;
    logic [31:0]   r_data;

    logic [WW-1:0]            one, f, s, nf2;
    logic [2*WW:0]            prod;
    logic [tsw_pkg::IDX_W-1:0] ax, ay;
    logic [AW-1:0]            addr;
    logic                     wr_en;
    logic [31:0]              blend;
    logic                     out_free;

    assign one      = WW'(1) << F;
    assign f        = r_sel ? r_fy : r_fx;
    assign out_free = !r_ov || i_ready;
    assign o_valid  = r_ov;
    assign o_data   = r_data;
    assign o_pop    = (r_st == ST_IDLE) && i_q_valid;

    // smoothstep: one multiplier shared over two steps per coordinate
    always_comb begin
        if (r_st == ST_SM1) prod = (2*WW+1)'(f) * (2*WW+1)'(f);
        else prod = (2*WW+1)'(r_f2) * (2*WW+1)'((WW+1)'(3) * (WW+1)'(one)
                                                - (WW+1)'(2) * (WW+1)'(f));
        nf2 = WW'((prod + (2*WW+1)'(one >> 1)) >> F);
        s   = nf2;
    end

    // fetch order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    always_comb begin
        ax = r_rc[0] ? r_job.x1 : r_job.x0;
        ay = r_rc[1] ? r_job.y1 : r_job.y0;
        if (r_st == ST_IDLE) begin
            ax = i_job.x0;
            ay = i_job.y0;
        end
        addr  = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);
        wr_en = o_pop && i_job.op == tsw_pkg::OP_WRITE;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[addr] <= i_job.color;
        r_mem_q <= r_mem[addr];
    end

    always_comb begin
        logic [SW-1:0] sum;
        logic [SW-1:0] ch;
        blend = '0;
        for (int k = 0; k < 4; k++) begin
            sum = SW'(r_top[k]) * SW'(one - r_fy) + SW'(r_bot[k]) * SW'(r_fy);
            ch  = (sum + (SW'(1) << (2*F - 1))) >> (2*F);
            blend[8*k +: 8] = (ch > SW'(255)) ? 8'hff : ch[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_ov <= ((r_st == ST_OUT) && out_free) || (r_ov && !i_ready);
            case (r_st)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_sel <= 1'b0;
                        r_rc  <= 3'd0;
                        r_fx  <= WW'(i_job.fx);
                        r_fy  <= WW'(i_job.fy);
                        if (i_job.white) begin
                            r_res <= '1;
                            r_st  <= ST_OUT;
                        end else if (i_job.op == tsw_pkg::OP_READ) begin
                            r_st <= (i_filter == tsw_pkg::FILT_SMOOTH) ? ST_SM1 : ST_RD;
                        end
                    end
                end
                ST_SM1: begin
                    r_f2 <= nf2;
                    r_st <= ST_SM2;
                end
                ST_SM2: begin
                    if (r_sel) r_fy <= s;
                    else r_fx <= s;
                    r_sel <= 1'b1;
                    r_st  <= r_sel ? ST_RD : ST_SM1;
                end
                ST_RD: begin
                    // read data arrives in the cycle after its address is presented
                    if (r_rc != 3'd0) r_tex[r_rc[1:0] - 2'd1] <= r_mem_q;
                    r_rc <= r_rc + 3'd1;
                    if (r_rc == 3'd4) begin
                        if (i_filter == tsw_pkg::FILT_NEAREST) begin
                            r_res <= r_tex[0];
                            r_st  <= ST_OUT;
                        end else begin
                            r_st <= ST_HOR;
                        end
                    end
                end
                ST_HOR: begin
                    for (int k = 0; k < 4; k++) begin
                        r_top[k] <= TW'(r_tex[0][8*k +: 8]) * TW'(one - r_fx)
                                  + TW'(r_tex[1][8*k +: 8]) * TW'(r_fx);
                        r_bot[k] <= TW'(r_tex[2][8*k +: 8]) * TW'(one - r_fx)
                                  + TW'(r_tex[3][8*k +: 8]) * TW'(r_fx);
                    end
                    r_st <= ST_VER;
                end
                ST_VER: begin
                    r_res <= blend;
                    r_st  <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_st == ST_OUT && out_free) r_data <= r_res;
    end
endmodule

// File: rtl/texture_sampler_wrap_filter.sv
// Top level of the texture sampler: configuration registers, front, queue, back.
// Depends on tsw_pkg, tsw_front, tsw_queue, tsw_back.
//
//  channel  | dir | handshake                      | content
//  s_axis   | in  | s_axis_tvalid / s_axis_tready  | tuser op, tdata coords and colour
//  m_axis   | out | m_axis_tvalid / m_axis_tready  | tdata filtered RGBA
//  cfg      | in  | i_cfg_valid / o_cfg_ready      | register index and value
//
// Front takes a beat a cycle into a 4-deep queue while the queue has room; the back
// serves one job at a time. A read runs smoothstep (shared multiplier) if set, four
// taps in turn via the single memory read port, then the blend unless nearest; with
// no texture attached, straight out. Reset is synchronous; texel memory is not cleared.
// Output stall holds the back in its output state while the queue keeps filling.
module texture_sampler_wrap_filter #(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // u_coord, v_coord, write_red/green/blue/alpha
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // sample_red, green, blue, alpha
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    tsw_pkg::t_cfg r_cfg;
    tsw_pkg::t_job f_job, q_job;
    logic          push, q_ready, q_valid, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_mode      <= tsw_pkg::WRAP_CLAMP;
            r_cfg.filter_mode    <= tsw_pkg::FILT_NEAREST;
            r_cfg.tex_width      <= 9'd256;
            r_cfg.tex_height     <= 9'd256;
            r_cfg.source_present <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tsw_pkg::REG_WRAP:   r_cfg.wrap_mode      <= i_cfg_data[1:0];
                tsw_pkg::REG_FILTER: r_cfg.filter_mode    <= i_cfg_data[1:0];
                tsw_pkg::REG_WIDTH:  r_cfg.tex_width      <= i_cfg_data;
                tsw_pkg::REG_HEIGHT: r_cfg.tex_height     <= i_cfg_data;
                tsw_pkg::REG_SOURCE: r_cfg.source_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tsw_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_op(s_axis_tuser),
        .i_u(s_axis_tdata[19:0]), .i_v(s_axis_tdata[39:20]),
        .i_color(s_axis_tdata[71:40]),
        .o_push(push), .o_job(f_job), .i_q_ready(q_ready)
    );

    tsw_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(f_job),
        .o_ready(q_ready), .o_valid(q_valid), .o_job(q_job), .i_pop(pop)
    );

    tsw_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_filter(r_cfg.filter_mode),
        .i_q_valid(q_valid), .i_job(q_job), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_ready) else $error("push into full queue");
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid) else $error("pop from empty queue");
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("result valid after reset");
endmodule
